/* rtl/core/agr_pkg.sv */
// Shared types, register codes and pixel unpacking for the antialiased glyph rasterizer.
package agr_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_BPP_SELECT = 2'd0;
	localparam logic [1:0] REG_TEXT_COLOR = 2'd1;
	localparam logic [1:0] REG_BG_COLOR   = 2'd2;

	// bits-per-pixel select codes
	localparam logic [1:0] BPP_1 = 2'd0;
	localparam logic [1:0] BPP_2 = 2'd1;
	localparam logic [1:0] BPP_4 = 2'd2;
	localparam logic [1:0] BPP_8 = 2'd3;

	// pixel slots in one bitmap byte at most
	localparam int SLOTS = 8;
	localparam int SLOT_W = $clog2(SLOTS);

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one classified byte, handed from front to back
	typedef struct packed {
		logic [7:0]  bitmap;   // raw packed byte
		logic [7:0]  emit;     // slot i produces a pixel write
		logic [15:0] x_base;   // x of slot 0
		logic [15:0] y;        // row coordinate
	} agr_entry_t;

	// active configuration, shared by front and back
	typedef struct packed {
		logic [1:0]  bpp_sel;
		logic [15:0] text;
		logic [15:0] bg;
	} agr_cfg_t;

	// intensity of pixel slot i, most significant pixel first
	function automatic logic [7:0] pix_level(input logic [7:0] b, input logic [1:0] sel,
			input logic [SLOT_W-1:0] i);
		logic [7:0] lvl;
		lvl = 8'd0;
		unique case (sel)
			BPP_1: lvl = {7'd0, b[3'd7 - i]};
			BPP_2: lvl = (b >> {~i[1:0], 1'b0}) & 8'h03;
			BPP_4: lvl = (b >> {~i[0], 2'b00}) & 8'h0F;
			BPP_8: lvl = b;
			default: lvl = 8'd0;
		endcase
		return lvl;
	endfunction

	// full-scale intensity for a bits-per-pixel code
	function automatic logic [7:0] level_mask(input logic [1:0] sel);
		logic [7:0] m;
		m = 8'hFF;
		unique case (sel)
			BPP_1: m = 8'h01;
			BPP_2: m = 8'h03;
			BPP_4: m = 8'h0F;
			BPP_8: m = 8'hFF;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/antialiased_glyph_rasterizer.sv */
// An accepted byte passes the queue, slot select stage, product stage and output
// register. Throughput: one pixel write per cycle while out_stall is low; the slot
// walker emits a byte's visible pixels (1 to 8) and drops a byte that yields none.
// A two-entry queue lets bytes be accepted while earlier pixels are still emitted.
// Reset (arst_n, asynchronous) restores the configuration registers, clears counters and queue.
module antialiased_glyph_rasterizer import agr_pkg::*; #(
	parameter int COLOR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// bitmap bytes
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  glyph_bits,
	input  logic        start_of_glyph,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [7:0]  glyph_width,
	// pixel writes
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [15:0] pixel_rgb,
	output logic        last_of_byte
);

	agr_cfg_t   cfg_q;
	agr_entry_t entry, head;
	logic       accept, full, empty, pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp_sel <= BPP_1;
			cfg_q.text    <= 16'hFFFF;
			cfg_q.bg      <= 16'h0000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BPP_SELECT: cfg_q.bpp_sel <= cfg_data[1:0];
				REG_TEXT_COLOR: cfg_q.text    <= cfg_data;
				REG_BG_COLOR:   cfg_q.bg      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	agr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.accept         (accept),
		.glyph_bits     (glyph_bits),
		.start_of_glyph (start_of_glyph),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.glyph_width    (glyph_width),
		.entry          (entry)
	);

	agr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	agr_back #(
		.COLOR_BITS (COLOR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_rgb    (pixel_rgb),
		.last_of_byte (last_of_byte)
	);

endmodule

/* rtl/core/agr_front.sv */
// Front end: accepts bitmap bytes, tracks glyph position and classifies pixel slots.
module agr_front import agr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  agr_cfg_t    cfg,
	input  logic        accept,
	input  logic [7:0]  glyph_bits,
	input  logic        start_of_glyph,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [7:0]  glyph_width,
	output agr_entry_t  entry
);

	logic [15:0] lx_q, ly_q;
	logic [7:0]  lw_q, bc_q, row_q;

	logic [15:0] eff_x, eff_y;
	logic [7:0]  eff_w, eff_bc, eff_row;
	logic [10:0] col_base;
	logic [3:0]  ppb;
	logic [8:0]  row_bytes;
	logic [8:0]  bc_next;
	logic [7:0]  emit;

	// origin, width and counters as seen by this byte
	always_comb begin
		eff_x   = start_of_glyph ? origin_x : lx_q;
		eff_y   = start_of_glyph ? origin_y : ly_q;
		eff_w   = start_of_glyph ? ((glyph_width == 8'd0) ? 8'd1 : glyph_width) : lw_q;
		eff_bc  = start_of_glyph ? 8'd0 : bc_q;
		eff_row = start_of_glyph ? 8'd0 : row_q;
	end

	// pixels per byte, first column and row length in bytes
	always_comb begin
		ppb = 4'd8 >> cfg.bpp_sel;
		col_base = {3'd0, eff_bc} << (2'd3 - cfg.bpp_sel);
		row_bytes = ({1'b0, eff_w} + {5'd0, ppb} - 9'd1) >> (2'd3 - cfg.bpp_sel);
		bc_next = {1'b0, eff_bc} + 9'd1;
	end

	// slot classification: in range, inside the glyph and not transparent
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			emit[i] = (4'(i) < ppb)
				&& ((col_base + 11'(i)) < {3'd0, eff_w})
				&& (pix_level(glyph_bits, cfg.bpp_sel, SLOT_W'(i)) != 8'd0);
		end
	end

	assign entry.bitmap = glyph_bits;
	assign entry.emit   = emit;
	assign entry.x_base = eff_x + {5'd0, col_base};
	assign entry.y      = eff_y + {8'd0, eff_row};

	// glyph latches and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q  <= 16'd0;
			ly_q  <= 16'd0;
			lw_q  <= 8'd1;
			bc_q  <= 8'd0;
			row_q <= 8'd0;
		end else if (accept) begin
			lx_q <= eff_x;
			ly_q <= eff_y;
			lw_q <= eff_w;
			if ({1'b0, bc_next[7:0]} >= row_bytes) begin
				bc_q  <= 8'd0;
				row_q <= eff_row + 8'd1;
			end else begin
				bc_q  <= bc_next[7:0];
				row_q <= eff_row;
			end
		end
	end

endmodule

/* rtl/core/agr_queue.sv */
// Short FIFO between the classifying front end and the pixel back end.
module agr_queue import agr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  agr_entry_t wr_entry,
	input  logic       pop,
	output agr_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	agr_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill level out of range");

endmodule

/* rtl/core/agr_back.sv */
// Back end: walks queued bytes' slots and blends one pixel per cycle unless stalled.
module agr_back import agr_pkg::*; #(
	parameter int COLOR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  agr_cfg_t    cfg,
	input  agr_entry_t  head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [15:0] pixel_rgb,
	output logic        last_of_byte
);

	localparam logic [15:0] COLOR_MASK = (COLOR_BITS >= 16) ? 16'hFFFF
		: 16'((32'd1 << COLOR_BITS) - 32'd1);

	logic              en;
	logic              first_q;
	logic [7:0]        rem_q;
	logic [7:0]        cur, left, pick_bit;
	logic [SLOT_W-1:0] pick;
	logic              issue;

	// slot select stage
	logic        s1_valid;
	logic [15:0] s1_x, s1_y;
	logic [7:0]  s1_level;
	logic        s1_last;

	// product stage
	logic        s2_valid;
	logic [15:0] s2_x, s2_y;
	logic        s2_full, s2_last;
	logic [13:0] s2_pr, s2_pg, s2_pb;
	logic        s2_nr, s2_ng, s2_nb;

	// output register
	logic        out_valid_q;
	logic [15:0] out_x_q, out_y_q, out_color_q;
	logic        out_last_q;

	// channel differences for the blend
	logic [6:0]  dr, dg, db;
	logic [5:0]  mr, mg, mb;
	logic [4:0]  qr, qb;
	logic [5:0]  qg;
	logic [4:0]  cr, cb;
	logic [5:0]  cg;

	// truncating divide of a product magnitude by the intensity mask
	function automatic logic [7:0] div_mask(input logic [13:0] p, input logic [1:0] sel);
		logic [29:0] prod;
		logic [14:0] sum;
		logic [7:0]  q;
		prod = 30'd0;
		sum  = 15'd0;
		q    = 8'd0;
		unique case (sel)
			BPP_2: begin
				prod = {16'd0, p} * 30'h0000AAAB;
				q = 8'(prod >> 17);
			end
			BPP_4: begin
				prod = {16'd0, p} * 30'h00008889;
				q = 8'(prod >> 19);
			end
			BPP_8: begin
				sum = {1'b0, p} + {9'd0, p[13:8]} + 15'd1;
				q = 8'(sum >> 8);
			end
			default: q = p[7:0];
		endcase
		return q;
	endfunction

	assign en = !(out_valid_q && out_stall);

	// next slot to emit, lowest column first
	always_comb begin
		cur = first_q ? head.emit : rem_q;
		pick = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (cur[i]) begin
				pick = SLOT_W'(i);
			end
		end
		pick_bit = 8'd1 << pick;
		left  = cur & ~pick_bit;
		issue = en && !empty && (cur != 8'd0);
		pop   = en && !empty && (left == 8'd0);
	end

	// slot walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			rem_q   <= 8'd0;
		end else if (pop) begin
			first_q <= 1'b1;
		end else if (issue) begin
			first_q <= 1'b0;
			rem_q   <= left;
		end
	end

	// blend differences, sign and magnitude per channel
	always_comb begin
		dr = {2'd0, cfg.text[15:11]} - {2'd0, cfg.bg[15:11]};
		dg = {1'b0, cfg.text[10:5]} - {1'b0, cfg.bg[10:5]};
		db = {2'd0, cfg.text[4:0]} - {2'd0, cfg.bg[4:0]};
		mr = dr[6] ? 6'(-dr) : dr[5:0];
		mg = dg[6] ? 6'(-dg) : dg[5:0];
		mb = db[6] ? 6'(-db) : db[5:0];
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			s1_valid    <= issue;
			s2_valid    <= s1_valid;
			out_valid_q <= s2_valid;
		end
	end

	// slot select: coordinates and intensity
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_x     <= head.x_base + 16'(pick);
			s1_y     <= head.y;
			s1_level <= pix_level(head.bitmap, cfg.bpp_sel, pick);
			s1_last  <= (left == 8'd0);
		end
	end

	// products of channel difference and intensity
	always_ff @(posedge clk) begin
		if (en && s1_valid) begin
			s2_x    <= s1_x;
			s2_y    <= s1_y;
			s2_last <= s1_last;
			s2_full <= (s1_level == level_mask(cfg.bpp_sel));
			s2_pr   <= {8'd0, mr} * {6'd0, s1_level};
			s2_pg   <= {8'd0, mg} * {6'd0, s1_level};
			s2_pb   <= {8'd0, mb} * {6'd0, s1_level};
			s2_nr   <= dr[6];
			s2_ng   <= dg[6];
			s2_nb   <= db[6];
		end
	end

	// divide by the mask and add back to the background
	always_comb begin
		qr = 5'(div_mask(s2_pr, cfg.bpp_sel));
		qg = 6'(div_mask(s2_pg, cfg.bpp_sel));
		qb = 5'(div_mask(s2_pb, cfg.bpp_sel));
		cr = s2_nr ? cfg.bg[15:11] - qr : cfg.bg[15:11] + qr;
		cg = s2_ng ? cfg.bg[10:5] - qg : cfg.bg[10:5] + qg;
		cb = s2_nb ? cfg.bg[4:0] - qb : cfg.bg[4:0] + qb;
	end

	// output register
	always_ff @(posedge clk) begin
		if (en && s2_valid) begin
			out_x_q     <= s2_x;
			out_y_q     <= s2_y;
			out_last_q  <= s2_last;
			out_color_q <= (s2_full ? cfg.text : {cr, cg, cb}) & COLOR_MASK;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = out_x_q;
	assign pixel_y      = out_y_q;
	assign pixel_rgb    = out_color_q;
	assign last_of_byte = out_last_q;

endmodule
